FILE: design/ndm_pkg.sv
// Package for the descriptor nearest neighbor matcher.
// Holds sizes, widths, item and register codes, and the controller state type.
// No dependencies.
package ndm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int DIM        = 128;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 7;
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DESC_W     = 8;
    localparam int SQ_W       = 2 * DESC_W;
    localparam int DIST_W     = 24;
    localparam int POS_W      = 16;
    localparam int RATIO_W    = 8;
    localparam int RHS_W      = 2 * RATIO_W + DIST_W;
    localparam int PADDR_W    = 5;

    localparam logic [1:0] MODE_LOAD_DESC = 2'd0;
    localparam logic [1:0] MODE_LOAD_POS  = 2'd1;
    localparam logic [1:0] MODE_MATCH     = 2'd2;

    typedef enum logic [2:0] {
        REG_COUNT_A     = 3'd0,
        REG_COUNT_B     = 3'd1,
        REG_CROSS_CHECK = 3'd2,
        REG_RATIO_EN    = 3'd3,
        REG_RATIO_Q8    = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_B,
        ST_RATIO_MUL,
        ST_RATIO_CMP,
        ST_SCAN_A,
        ST_BACK_CMP,
        ST_POS_RD,
        ST_POS_OUT
    } state_t;

endpackage

FILE: design/descriptor_nearest_neighbor_matcher.sv
// Top level of the descriptor nearest neighbor matcher: APB registers,
// descriptor and position memories, distance scan engine and controller.
// Depends on ndm_pkg and ndm_ram.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  item in   | start, busy             | mode which_set row column value pos_x/y
//  result    | done (one-cycle strobe) | matched src/dst_index src/dst_x/y
//  config    | APB psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// Loads and rejected queries: result in the cycle after the item, busy stays low.
// Match (counts clamped to MAX_POINTS): scan set B, ratio test, then with cross
// check scan set A and back compare, then read positions; a ratio-test reject or
// back-compare mismatch ends the match early. The byte-serial distance engine reads
// one element of each descriptor memory per cycle. busy holds for the whole match.
// Reset clears the controller and registers; memories are not cleared.
// The result receiver cannot stall; done is a single-cycle strobe.
module descriptor_nearest_neighbor_matcher
    import ndm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic                 which_set,
    input  logic [ROW_W-1:0]     row,
    input  logic [COL_W-1:0]     column,
    input  logic [DESC_W-1:0]    value,
    input  logic [POS_W-1:0]     pos_x,
    input  logic [POS_W-1:0]     pos_y,
    output logic                 done,
    output logic                 matched,
    output logic [ROW_W-1:0]     src_index,
    output logic [ROW_W-1:0]     dst_index,
    output logic [POS_W-1:0]     src_x,
    output logic [POS_W-1:0]     src_y,
    output logic [POS_W-1:0]     dst_x,
    output logic [POS_W-1:0]     dst_y,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Configuration registers
    logic [CNT_W-1:0]   count_a_reg, count_b_reg;
    logic               cross_en_reg, ratio_en_reg;
    logic [RATIO_W-1:0] ratio_reg;
    reg_idx_t           cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            cross_en_reg <= 1'b1;
            ratio_en_reg <= 1'b1;
            ratio_reg    <= RATIO_W'(102);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_COUNT_A:     count_a_reg  <= pwdata[CNT_W-1:0];
                REG_COUNT_B:     count_b_reg  <= pwdata[CNT_W-1:0];
                REG_CROSS_CHECK: cross_en_reg <= pwdata[0];
                REG_RATIO_EN:    ratio_en_reg <= pwdata[0];
                REG_RATIO_Q8:    ratio_reg    <= pwdata[RATIO_W-1:0];
                default:         ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_COUNT_A:     prdata = 32'(count_a_reg);
            REG_COUNT_B:     prdata = 32'(count_b_reg);
            REG_CROSS_CHECK: prdata = 32'(cross_en_reg);
            REG_RATIO_EN:    prdata = 32'(ratio_en_reg);
            REG_RATIO_Q8:    prdata = 32'(ratio_reg);
            default:         prdata = '0;
        endcase
    end

    // Clamp counts to the memory size
    logic [CNT_W-1:0] na, nb;
    assign na = (count_a_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_a_reg;
    assign nb = (count_b_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_b_reg;

    // Item decode
    state_t state_reg, state_next;
    logic   accept, is_match, query_ok;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign is_match = (mode == MODE_MATCH);
    assign query_ok = ({1'b0, row} < na) && (nb != '0);

    // Scan engine registers
    logic [ROW_W-1:0]   row_reg, nn_reg;
    logic [ROW_W-1:0]   i_reg;
    logic [COL_W-1:0]   k_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               issue_reg;
    logic               p1_valid_reg, p1_first_reg, p1_last_reg, p1_fin_reg;
    logic [ROW_W-1:0]   p1_idx_reg;
    logic               p2_valid_reg, p2_first_reg, p2_last_reg, p2_fin_reg;
    logic [ROW_W-1:0]   p2_idx_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [DIST_W-1:0]  acc_reg, bd_reg, sd_reg;
    logic [ROW_W-1:0]   bi_reg;
    logic               have_reg, have2_reg;
    logic [SQ_W-1:0]    rsq_reg;
    logic [RHS_W-1:0]   rhs_reg;

    // Memories
    logic [DESC_W-1:0]  da_rdata, db_rdata;
    logic [ADDR_W-1:0]  da_raddr, db_raddr, d_waddr;
    logic [2*POS_W-1:0] pa_rdata, pb_rdata;
    logic               da_we, db_we, pa_we, pb_we;

    assign d_waddr = {row, column};
    assign da_we   = accept && (mode == MODE_LOAD_DESC) && !which_set;
    assign db_we   = accept && (mode == MODE_LOAD_DESC) && which_set;
    assign pa_we   = accept && (mode == MODE_LOAD_POS) && !which_set;
    assign pb_we   = accept && (mode == MODE_LOAD_POS) && which_set;

    // Query row is fixed in set A for the first scan, chosen B row for the second
    assign da_raddr = (state_reg == ST_SCAN_A) ? {i_reg, k_reg} : {row_reg, k_reg};
    assign db_raddr = (state_reg == ST_SCAN_A) ? {nn_reg, k_reg} : {i_reg, k_reg};

    ndm_ram #(.WIDTH(DESC_W), .DEPTH(MAX_POINTS * DIM)) u_desc_a (
        .clk(clk), .we(da_we), .waddr(d_waddr), .wdata(value),
        .raddr(da_raddr), .rdata(da_rdata)
    );

    ndm_ram #(.WIDTH(DESC_W), .DEPTH(MAX_POINTS * DIM)) u_desc_b (
        .clk(clk), .we(db_we), .waddr(d_waddr), .wdata(value),
        .raddr(db_raddr), .rdata(db_rdata)
    );

    ndm_ram #(.WIDTH(2 * POS_W), .DEPTH(MAX_POINTS)) u_pos_a (
        .clk(clk), .we(pa_we), .waddr(row), .wdata({pos_x, pos_y}),
        .raddr(row_reg), .rdata(pa_rdata)
    );

    ndm_ram #(.WIDTH(2 * POS_W), .DEPTH(MAX_POINTS)) u_pos_b (
        .clk(clk), .we(pb_we), .waddr(row), .wdata({pos_x, pos_y}),
        .raddr(nn_reg), .rdata(pb_rdata)
    );

    // Element distance and row sum
    logic [DESC_W-1:0] absdiff;
    logic [DIST_W-1:0] row_dist;
    logic              scan_done, ratio_fail, row_last, elem_last;

    assign absdiff   = (da_rdata >= db_rdata) ? (da_rdata - db_rdata) : (db_rdata - da_rdata);
    assign row_dist  = (p2_first_reg ? '0 : acc_reg) + DIST_W'(sq_reg);
    assign scan_done = p2_valid_reg && p2_fin_reg;
    assign ratio_fail = ratio_en_reg && have2_reg
                        && ({bd_reg, 16'b0} > rhs_reg);
    assign elem_last = (k_reg == COL_W'(DIM - 1));
    assign row_last  = ({1'b0, i_reg} == n_reg - CNT_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_match && query_ok)
                begin
                    state_next = ST_SCAN_B;
                end
            end
            ST_SCAN_B:
            begin
                if (scan_done)
                begin
                    state_next = ST_RATIO_MUL;
                end
            end
            ST_RATIO_MUL:
            begin
                state_next = ST_RATIO_CMP;
            end
            ST_RATIO_CMP:
            begin
                if (ratio_fail)
                begin
                    state_next = ST_IDLE;
                end
                else if (cross_en_reg)
                begin
                    state_next = ST_SCAN_A;
                end
                else
                begin
                    state_next = ST_POS_RD;
                end
            end
            ST_SCAN_A:
            begin
                if (scan_done)
                begin
                    state_next = ST_BACK_CMP;
                end
            end
            ST_BACK_CMP:
            begin
                state_next = (bi_reg == row_reg) ? ST_POS_RD : ST_IDLE;
            end
            ST_POS_RD:
            begin
                state_next = ST_POS_OUT;
            end
            ST_POS_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result registers
    logic               done_reg, matched_reg;
    logic [ROW_W-1:0]   src_index_reg, dst_index_reg;
    logic [POS_W-1:0]   src_x_reg, src_y_reg, dst_x_reg, dst_y_reg;

    // Scan datapath and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            nn_reg        <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            issue_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p1_first_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            p1_fin_reg    <= 1'b0;
            p1_idx_reg    <= '0;
            p2_valid_reg  <= 1'b0;
            p2_first_reg  <= 1'b0;
            p2_last_reg   <= 1'b0;
            p2_fin_reg    <= 1'b0;
            p2_idx_reg    <= '0;
            sq_reg        <= '0;
            acc_reg       <= '0;
            bd_reg        <= '0;
            sd_reg        <= '0;
            bi_reg        <= '0;
            have_reg      <= 1'b0;
            have2_reg     <= 1'b0;
            rsq_reg       <= '0;
            rhs_reg       <= '0;
            done_reg      <= 1'b0;
            matched_reg   <= 1'b0;
            src_index_reg <= '0;
            dst_index_reg <= '0;
            src_x_reg     <= '0;
            src_y_reg     <= '0;
            dst_x_reg     <= '0;
            dst_y_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Issue one element per cycle
            p1_valid_reg <= issue_reg;
            p1_first_reg <= (k_reg == '0);
            p1_last_reg  <= elem_last;
            p1_fin_reg   <= elem_last && row_last;
            p1_idx_reg   <= i_reg;
            if (issue_reg)
            begin
                k_reg <= elem_last ? '0 : k_reg + COL_W'(1);
                if (elem_last)
                begin
                    i_reg <= i_reg + ROW_W'(1);
                    if (row_last)
                    begin
                        issue_reg <= 1'b0;
                    end
                end
            end

            // Square the element difference
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;
            p2_fin_reg   <= p1_fin_reg;
            p2_idx_reg   <= p1_idx_reg;
            sq_reg       <= absdiff * absdiff;

            // Accumulate and track nearest and second nearest
            if (p2_valid_reg)
            begin
                acc_reg <= row_dist;
                if (p2_last_reg)
                begin
                    if (!have_reg || row_dist < bd_reg)
                    begin
                        if (have_reg)
                        begin
                            sd_reg    <= bd_reg;
                            have2_reg <= 1'b1;
                        end
                        bd_reg   <= row_dist;
                        bi_reg   <= p2_idx_reg;
                        have_reg <= 1'b1;
                    end
                    else if (!have2_reg || row_dist < sd_reg)
                    begin
                        sd_reg    <= row_dist;
                        have2_reg <= 1'b1;
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        row_reg       <= row;
                        rsq_reg       <= ratio_reg * ratio_reg;
                        done_reg      <= !(is_match && query_ok);
                        matched_reg   <= 1'b0;
                        src_index_reg <= is_match ? row : '0;
                        dst_index_reg <= '0;
                        src_x_reg     <= '0;
                        src_y_reg     <= '0;
                        dst_x_reg     <= '0;
                        dst_y_reg     <= '0;
                        if (is_match && query_ok)
                        begin
                            i_reg     <= '0;
                            k_reg     <= '0;
                            n_reg     <= nb;
                            issue_reg <= 1'b1;
                            have_reg  <= 1'b0;
                            have2_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN_B:
                begin
                end
                ST_RATIO_MUL:
                begin
                    // The last row of the scan has settled into bi_reg by now
                    nn_reg  <= bi_reg;
                    rhs_reg <= RHS_W'(rsq_reg) * RHS_W'(sd_reg);
                end
                ST_RATIO_CMP:
                begin
                    if (ratio_fail)
                    begin
                        done_reg <= 1'b1;
                    end
                    else if (cross_en_reg)
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        n_reg     <= na;
                        issue_reg <= 1'b1;
                        have_reg  <= 1'b0;
                        have2_reg <= 1'b0;
                    end
                end
                ST_SCAN_A:
                begin
                end
                ST_BACK_CMP:
                begin
                    // Drop the match when the back match differs
                    if (bi_reg != row_reg)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                ST_POS_RD:
                begin
                end
                ST_POS_OUT:
                begin
                    done_reg      <= 1'b1;
                    matched_reg   <= 1'b1;
                    dst_index_reg <= nn_reg;
                    src_x_reg     <= pa_rdata[2*POS_W-1:POS_W];
                    src_y_reg     <= pa_rdata[POS_W-1:0];
                    dst_x_reg     <= pb_rdata[2*POS_W-1:POS_W];
                    dst_y_reg     <= pb_rdata[POS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign matched   = matched_reg;
    assign src_index = src_index_reg;
    assign dst_index = dst_index_reg;
    assign src_x     = src_x_reg;
    assign src_y     = src_y_reg;
    assign dst_x     = dst_x_reg;
    assign dst_y     = dst_y_reg;

`ifndef SYNTHESIS
    // A load item gives its result in the next cycle
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_match) |=> done)
        else $error("load item without result");

    // Results appear only once the controller is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // The scan never issues a row beyond the count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> ({1'b0, i_reg} < n_reg))
        else $error("scan row out of range");

    // A matched result always names the chosen row
    a_match_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (done && matched) |-> (dst_index == nn_reg))
        else $error("matched index mismatch");
`endif

endmodule

FILE: design/ndm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ndm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: test/tb_descriptor_nearest_neighbor_matcher.sv
// Self-checking testbench for descriptor_nearest_neighbor_matcher.
// Loads small descriptor sets, sweeps register settings, and checks each result against
// an in-bench predictor. Depends on ndm_pkg and the design under test.
`timescale 1ns / 100ps

module tb_descriptor_nearest_neighbor_matcher;
    import ndm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         ROWS_USED   = 4;

    typedef struct {
        logic [1:0]        mode;
        logic              which_set;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [DESC_W-1:0] value;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } cmd_t;

    typedef struct {
        logic              matched;
        logic [ROW_W-1:0]  src_index;
        logic [ROW_W-1:0]  dst_index;
        logic [POS_W-1:0]  src_x;
        logic [POS_W-1:0]  src_y;
        logic [POS_W-1:0]  dst_x;
        logic [POS_W-1:0]  dst_y;
    } match_t;

    // Predicts match results from the loaded sets and the register copy
    class match_scoreboard;
        logic [DESC_W-1:0] desc_a [MAX_POINTS*DIM];
        logic [DESC_W-1:0] desc_b [MAX_POINTS*DIM];
        logic [31:0]       pos_a [MAX_POINTS];
        logic [31:0]       pos_b [MAX_POINTS];
        logic [CNT_W-1:0]  count_a = '0;
        logic [CNT_W-1:0]  count_b = '0;
        logic              cross_en = 1'b1;
        logic              ratio_en = 1'b1;
        logic [RATIO_W-1:0] ratio_q8 = 8'd102;
        match_t            pending_q[$];

        function void set_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_COUNT_A:     count_a = data[CNT_W-1:0];
                REG_COUNT_B:     count_b = data[CNT_W-1:0];
                REG_CROSS_CHECK: cross_en = data[0];
                REG_RATIO_EN:    ratio_en = data[0];
                REG_RATIO_Q8:    ratio_q8 = data[RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        // Scan n rows of the other set for the nearest and second-nearest row
        function void scan_rows(input bit query_b, input int unsigned qrow,
                                input int unsigned n, output int unsigned best,
                                output longint unsigned d1, output longint unsigned d2,
                                output bit has2);
            longint unsigned d;
            int diff;
            bit have;
            best = 0; d1 = 0; d2 = 0; has2 = 0; have = 0;
            for (int unsigned i = 0; i < n; i++)
            begin
                d = 0;
                for (int k = 0; k < DIM; k++)
                begin
                    if (query_b)
                        diff = int'(desc_b[qrow*DIM+k]) - int'(desc_a[i*DIM+k]);
                    else
                        diff = int'(desc_a[qrow*DIM+k]) - int'(desc_b[i*DIM+k]);
                    d += longint'(diff * diff);
                end
                if (!have || d < d1)
                begin
                    if (have)
                    begin
                        d2 = d1;
                        has2 = 1;
                    end
                    d1 = d;
                    best = i;
                    have = 1;
                end
                else if (!has2 || d < d2)
                begin
                    d2 = d;
                    has2 = 1;
                end
            end
        endfunction

        function void note_item(cmd_t c);
            match_t r;
            int unsigned na, nb, nn, back;
            longint unsigned d1, d2, e1, e2;
            bit has2, h2, ok;
            r = '{default: '0};
            case (c.mode)
                MODE_LOAD_DESC:
                    if (c.which_set) desc_b[c.row*DIM+c.column] = c.value;
                    else desc_a[c.row*DIM+c.column] = c.value;
                MODE_LOAD_POS:
                    if (c.which_set) pos_b[c.row] = {c.pos_x, c.pos_y};
                    else pos_a[c.row] = {c.pos_x, c.pos_y};
                MODE_MATCH:
                begin
                    na = (count_a > CNT_W'(MAX_POINTS)) ? MAX_POINTS : 32'(count_a);
                    nb = (count_b > CNT_W'(MAX_POINTS)) ? MAX_POINTS : 32'(count_b);
                    r.src_index = c.row;
                    ok = (c.row < na) && (nb > 0);
                    nn = 0;
                    if (ok)
                    begin
                        scan_rows(0, c.row, nb, nn, d1, d2, has2);
                        if (ratio_en && has2 &&
                            d1 * 65536 > longint'(ratio_q8) * ratio_q8 * d2)
                            ok = 0;
                    end
                    if (ok && cross_en)
                    begin
                        scan_rows(1, nn, na, back, e1, e2, h2);
                        if (back != c.row) ok = 0;
                    end
                    if (ok)
                    begin
                        r.matched = 1;
                        r.dst_index = nn[ROW_W-1:0];
                        {r.src_x, r.src_y} = pos_a[c.row];
                        {r.dst_x, r.dst_y} = pos_b[nn];
                    end
                end
                default: ;
            endcase
            pending_q = {pending_q, r};
        endfunction

        // Compare against the oldest prediction; empty string means a clean result
        function string check(match_t got);
            match_t e;
            if (pending_q.size() == 0)
                return "result with no item outstanding";
            e = pending_q.pop_front();
            if (got.matched !== e.matched)
                return $sformatf("matched %0d, want %0d (src %0d)", got.matched,
                                 e.matched, e.src_index);
            if (got.src_index !== e.src_index)
                return $sformatf("src_index %0d, want %0d", got.src_index, e.src_index);
            if (got.dst_index !== e.dst_index)
                return $sformatf("dst_index %0d, want %0d", got.dst_index, e.dst_index);
            if (got.src_x !== e.src_x || got.src_y !== e.src_y)
                return $sformatf("src pos %h/%h, want %h/%h", got.src_x, got.src_y,
                                 e.src_x, e.src_y);
            if (got.dst_x !== e.dst_x || got.dst_y !== e.dst_y)
                return $sformatf("dst pos %h/%h, want %h/%h", got.dst_x, got.dst_y,
                                 e.dst_x, e.dst_y);
            return "";
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] mode = MODE_LOAD_DESC;
    logic which_set = 1'b0;
    logic [ROW_W-1:0] row = '0;
    logic [COL_W-1:0] column = '0;
    logic [DESC_W-1:0] value = '0;
    logic [POS_W-1:0] pos_x = '0;
    logic [POS_W-1:0] pos_y = '0;
    logic done, matched;
    logic [ROW_W-1:0] src_index, dst_index;
    logic [POS_W-1:0] src_x, src_y, dst_x, dst_y;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    match_scoreboard sb = new();
    int mismatch_count = 0;

    descriptor_nearest_neighbor_matcher uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Check every strobed result
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && done)
        begin
            msg = sb.check('{matched, src_index, dst_index, src_x, src_y, dst_x, dst_y});
            if (msg != "") report(msg);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one item and hold it until the block takes it
    task automatic send_item(cmd_t c, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= c.mode;
        which_set <= c.which_set;
        row <= c.row;
        column <= c.column;
        value <= c.value;
        pos_x <= c.pos_x;
        pos_y <= c.pos_y;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(c);
    endtask

    // Drain all outstanding results before touching registers
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.mode = 2'($urandom_range(0, 3));
        c.which_set = 1'($urandom_range(0, 1));
        c.row = ROW_W'($urandom_range(0, MAX_POINTS - 1));
        c.column = COL_W'($urandom_range(0, DIM - 1));
        c.value = DESC_W'($urandom_range(0, 255));
        c.pos_x = POS_W'($urandom);
        c.pos_y = POS_W'($urandom);
        return c;
    endfunction

    function automatic cmd_t load_cmd(logic [1:0] m, logic s, int r, int col, int v);
        cmd_t c;
        c = rand_cmd();
        c.mode = m;
        c.which_set = s;
        c.row = ROW_W'(r);
        c.column = COL_W'(col);
        c.value = DESC_W'(v);
        return c;
    endfunction

    initial
    begin
        logic [DESC_W-1:0] base [ROWS_USED][DIM];
        int settings [7][5] = '{
            '{4, 4, 1, 1, 102},
            '{4, 4, 0, 0, 255},
            '{4, 1, 1, 1, 0},
            '{3, 4, 0, 1, 255},
            '{4, 2, 1, 0, 0},
            '{0, 2047, 1, 1, 255},
            '{4, 0, 0, 1, 17}
        };
        cmd_t c;
        int v, na, dice;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: extreme rows, columns, values and positions, unused mode
        c = load_cmd(MODE_LOAD_DESC, 1'b1, MAX_POINTS - 1, DIM - 1, 255);
        send_item(c, 0);
        c = load_cmd(MODE_LOAD_POS, 1'b0, MAX_POINTS - 1, 0, 0);
        c.pos_x = 16'hFFFF;
        c.pos_y = 16'h0000;
        send_item(c, 0);
        c.which_set = 1'b1;
        c.pos_x = 16'h0000;
        c.pos_y = 16'hFFFF;
        send_item(c, 1);
        c = rand_cmd();
        c.mode = MODE_UNUSED;
        send_item(c, 0);
        c.mode = MODE_MATCH;
        c.row = ROW_W'(MAX_POINTS - 1);
        send_item(c, 2);

        // Build the sets: B rows are exact or near copies of A rows, one is unrelated
        for (int r = 0; r < ROWS_USED; r++)
            for (int k = 0; k < DIM; k++)
                base[r][k] = DESC_W'($urandom_range(0, 255));
        for (int r = 0; r < ROWS_USED; r++)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                send_item(load_cmd(MODE_LOAD_DESC, 1'b0, r, k, base[r][k]), 0);
                case (r)
                    0: v = base[1][k];
                    1: v = base[0][k] + $urandom_range(0, 6);
                    2: v = $urandom_range(0, 255);
                    default: v = base[3][k] - $urandom_range(0, 4);
                endcase
                send_item(load_cmd(MODE_LOAD_DESC, 1'b1, r, k, v[7:0]),
                          (k % 40 == 0) ? pick_gap() : 0);
            end
            send_item(load_cmd(MODE_LOAD_POS, 1'b0, r, 0, 0), pick_gap());
            send_item(load_cmd(MODE_LOAD_POS, 1'b1, r, 0, 0), pick_gap());
        end
        drain();

        // Sweep register settings, each followed by mostly queries
        foreach (settings[p])
        begin
            write_reg(REG_COUNT_A, settings[p][0]);
            write_reg(REG_COUNT_B, settings[p][1]);
            write_reg(REG_CROSS_CHECK, settings[p][2]);
            write_reg(REG_RATIO_EN, settings[p][3]);
            write_reg(REG_RATIO_Q8, settings[p][4]);
            na = (settings[p][0] > 0) ? settings[p][0] : 1;
            for (int i = 0; i < 26; i++)
            begin
                c = rand_cmd();
                dice = $urandom_range(0, 99);
                if (dice < 60)
                begin
                    c.mode = MODE_MATCH;
                    if (dice < 52) c.row = ROW_W'($urandom_range(0, na - 1));
                end
                else if (dice < 80 && c.mode == MODE_LOAD_DESC)
                begin
                    // Nudge a row in use so nearest choices shift
                    c.row = ROW_W'($urandom_range(0, ROWS_USED - 1));
                end
                send_item(c, (p == 3) ? 0 : pick_gap());
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
design/ndm_pkg.sv
design/ndm_ram.sv
design/descriptor_nearest_neighbor_matcher.sv
test/tb_descriptor_nearest_neighbor_matcher.sv
